### hdl/msf_pkg.sv
// Shared types, constants and mask helpers for the monochrome span fill unit.
package msf_pkg;

	localparam int FRAME_BYTES_DEF = 4096;
	localparam int CFG_W           = 7;
	localparam int CFG_IDX_W       = 2;
	localparam int PROD_W          = 2 * CFG_W;
	localparam int MIN_SUM_W       = PROD_W + 1;

	localparam logic [CFG_IDX_W-1:0] REG_ROW_BYTES = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = CFG_IDX_W'(1);

	localparam logic [CFG_W-1:0] ROW_BYTES_RST = CFG_W'(2);
	localparam logic [CFG_W-1:0] ROW_COUNT_RST = CFG_W'(4);

	localparam logic OP_DRAW = 1'b0;
	localparam logic OP_READ = 1'b1;

	localparam logic [7:0] BYTE_ONES = 8'hFF;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CHECK,
		ST_ADDR,
		ST_RD_WAIT,
		ST_F_RD,
		ST_F_WR,
		ST_MID,
		ST_L_WR,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] read_byte;
		logic       bad;
	} result_t;

	// pixels from column x to the right edge of the byte (MSB is leftmost)
	function automatic logic [7:0] head_mask(input logic [2:0] x);
		head_mask = BYTE_ONES >> x;
	endfunction

	// pixels from the left edge of the byte through column x
	function automatic logic [7:0] tail_mask(input logic [2:0] x);
		tail_mask = BYTE_ONES << (3'd7 - x);
	endfunction

endpackage

### hdl/msf_mem.sv
// Single-port frame store byte memory with registered read data.
module msf_mem #(
	parameter int FRAME_BYTES = msf_pkg::FRAME_BYTES_DEF,
	parameter int AW          = $clog2(FRAME_BYTES)
) (
	input  logic          clk,
	input  logic          we,
	input  logic          re,
	input  logic [AW-1:0] addr,
	input  logic [7:0]    wdata,
	output logic [7:0]    rdata
);

	logic [7:0] mem [FRAME_BYTES];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

### hdl/msf_ctrl.sv
// Sequencer: range checks, address unit and span walk over the frame store.
module msf_ctrl #(
	parameter int FRAME_BYTES = msf_pkg::FRAME_BYTES_DEF,
	parameter int AW          = $clog2(FRAME_BYTES)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [msf_pkg::CFG_W-1:0] row_bytes,
	input  logic [msf_pkg::CFG_W-1:0] row_count,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     operation,
	input  logic [8:0]               x_start,
	input  logic [8:0]               x_end,
	input  logic [5:0]               row_index,
	input  logic [11:0]              read_address,
	output msf_pkg::result_t         res,
	input  logic                     res_take,
	output logic                     mem_we,
	output logic                     mem_re,
	output logic [AW-1:0]            mem_addr,
	output logic [7:0]               mem_wdata,
	input  logic [7:0]               mem_rdata
);

	localparam int PROD_W = msf_pkg::PROD_W;
	localparam int SUM_W = (AW + 1 > msf_pkg::MIN_SUM_W) ? AW + 1 : msf_pkg::MIN_SUM_W;
	localparam logic [AW-1:0]    LAST_ADDR = AW'(FRAME_BYTES - 1);
	localparam logic [SUM_W-1:0] STORE_LIM = SUM_W'(FRAME_BYTES);

	msf_pkg::state_t state_q, state_d;

	logic                        op_q;
	logic [8:0]                  xs_q, xe_q;
	logic [5:0]                  row_q;
	logic [11:0]                 addr_q;
	logic [msf_pkg::PROD_W-1:0]  prod_q;
	logic                        bad_q;
	logic                        single_q;
	logic [7:0]                  byte_q;
	logic [AW-1:0]               ptr_q, last_q;

	logic [msf_pkg::CFG_W-1:0]   mul_b;
	logic [msf_pkg::PROD_W-1:0]  prod;
	logic                        draw_bad;
	logic [SUM_W-1:0]            first_sum, last_sum, addr_ext;
	logic                        read_ok, past_store;

	// shared multiplier: row base for a draw, screen size for a read
	assign mul_b = (op_q == msf_pkg::OP_READ) ? row_count : {1'b0, row_q};
	assign prod  = PROD_W'(row_bytes) * PROD_W'(mul_b);

	assign draw_bad = (xe_q < xs_q) || ({1'b0, xe_q} >= {row_bytes, 3'b000})
		|| ({1'b0, row_q} >= row_count);

	assign first_sum  = SUM_W'(prod_q) + SUM_W'(xs_q[8:3]);
	assign last_sum   = SUM_W'(prod_q) + SUM_W'(xe_q[8:3]);
	assign past_store = last_sum >= STORE_LIM;
	assign addr_ext   = SUM_W'(addr_q);
	assign read_ok    = (addr_ext < SUM_W'(prod_q)) && (addr_ext < STORE_LIM);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= msf_pkg::ST_CLEAR;
			ptr_q   <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				msf_pkg::ST_CLEAR: ptr_q <= ptr_q + AW'(1);
				msf_pkg::ST_ADDR:  ptr_q <= AW'(first_sum);
				msf_pkg::ST_F_WR:  ptr_q <= ptr_q + AW'(1);
				msf_pkg::ST_MID: begin
					if (ptr_q != last_q) begin
						ptr_q <= ptr_q + AW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			msf_pkg::ST_IDLE: begin
				op_q   <= operation;
				xs_q   <= x_start;
				xe_q   <= x_end;
				row_q  <= row_index;
				addr_q <= read_address;
			end
			msf_pkg::ST_CHECK: begin
				prod_q <= prod;
				byte_q <= '0;
				bad_q  <= (op_q == msf_pkg::OP_DRAW) && draw_bad;
			end
			msf_pkg::ST_ADDR: begin
				last_q   <= AW'(last_sum);
				single_q <= first_sum == last_sum;
				if (op_q == msf_pkg::OP_READ) begin
					bad_q <= !read_ok;
				end else begin
					bad_q <= bad_q || past_store;
				end
			end
			msf_pkg::ST_RD_WAIT: byte_q <= mem_rdata;
			default: ;
		endcase
	end

	always_comb begin
		state_d       = state_q;
		in_ready      = 1'b0;
		mem_we        = 1'b0;
		mem_re        = 1'b0;
		mem_addr      = ptr_q;
		mem_wdata     = '0;
		res.valid     = 1'b0;
		res.read_byte = byte_q;
		res.bad       = bad_q;
		case (state_q)
			msf_pkg::ST_CLEAR: begin
				mem_we = 1'b1;
				if (ptr_q == LAST_ADDR) begin
					state_d = msf_pkg::ST_IDLE;
				end
			end
			msf_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = msf_pkg::ST_CHECK;
				end
			end
			msf_pkg::ST_CHECK: state_d = msf_pkg::ST_ADDR;
			msf_pkg::ST_ADDR: begin
				if (op_q == msf_pkg::OP_READ) begin
					if (read_ok) begin
						mem_re   = 1'b1;
						mem_addr = AW'(addr_ext);
						state_d  = msf_pkg::ST_RD_WAIT;
					end else begin
						state_d = msf_pkg::ST_FINISH;
					end
				end else if (bad_q || past_store) begin
					state_d = msf_pkg::ST_FINISH;
				end else begin
					state_d = msf_pkg::ST_F_RD;
				end
			end
			msf_pkg::ST_RD_WAIT: state_d = msf_pkg::ST_FINISH;
			msf_pkg::ST_F_RD: begin
				mem_re  = 1'b1;
				state_d = msf_pkg::ST_F_WR;
			end
			msf_pkg::ST_F_WR: begin
				mem_we    = 1'b1;
				mem_wdata = mem_rdata | (msf_pkg::head_mask(xs_q[2:0])
					& (single_q ? msf_pkg::tail_mask(xe_q[2:0]) : msf_pkg::BYTE_ONES));
				state_d   = single_q ? msf_pkg::ST_FINISH : msf_pkg::ST_MID;
			end
			msf_pkg::ST_MID: begin
				if (ptr_q == last_q) begin
					mem_re  = 1'b1;
					state_d = msf_pkg::ST_L_WR;
				end else begin
					mem_we    = 1'b1;
					mem_wdata = msf_pkg::BYTE_ONES;
				end
			end
			msf_pkg::ST_L_WR: begin
				mem_we    = 1'b1;
				mem_wdata = mem_rdata | msf_pkg::tail_mask(xe_q[2:0]);
				state_d   = msf_pkg::ST_FINISH;
			end
			msf_pkg::ST_FINISH: begin
				res.valid = 1'b1;
				if (res_take) begin
					state_d = msf_pkg::ST_IDLE;
				end
			end
			default: state_d = msf_pkg::ST_IDLE;
		endcase
	end

endmodule

### hdl/monochrome_span_fill_unit.sv
// Monochrome span fill unit: 1-bpp frame store with horizontal line draw and byte read.
// Throughput: one item at a time; middle bytes of a span are filled one store byte per cycle.
// Reset: arst_n clears control; the store is then zeroed one byte per cycle,
//   with in_ready low meanwhile. Config writes are always taken.
module monochrome_span_fill_unit #(
	parameter int FRAME_BYTES = msf_pkg::FRAME_BYTES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration write channel
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [msf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [msf_pkg::CFG_W-1:0]     cfg_data,
	// input item channel
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          operation,
	input  logic [8:0]                    x_start,
	input  logic [8:0]                    x_end,
	input  logic [5:0]                    row_index,
	input  logic [11:0]                   read_address,
	// result channel
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [7:0]                    read_byte,
	output logic                          bad_request
);

	localparam int AW = $clog2(FRAME_BYTES);

	logic [msf_pkg::CFG_W-1:0] row_bytes_q, row_count_q;
	msf_pkg::result_t          res;
	logic                      res_take;
	logic                      out_valid_q, bad_q;
	logic [7:0]                byte_q;
	logic                      mem_we, mem_re;
	logic [AW-1:0]             mem_addr;
	logic [7:0]                mem_wdata, mem_rdata;

	// Config registers: writes land at once; unknown indexes are dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_bytes_q <= msf_pkg::ROW_BYTES_RST;
			row_count_q <= msf_pkg::ROW_COUNT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				msf_pkg::REG_ROW_BYTES: row_bytes_q <= cfg_data;
				msf_pkg::REG_ROW_COUNT: row_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Output register: the sequencer hands its result over once this slot is
	// empty or being drained in the same cycle; a result held here does not
	// hold up the next input, but the sequencer waits while the slot stays full.
	assign res_take = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.valid && res_take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid && res_take) begin
			byte_q <= res.read_byte;
			bad_q  <= res.bad;
		end
	end

	assign out_valid   = out_valid_q;
	assign read_byte   = byte_q;
	assign bad_request = bad_q;

	// Sequencer: check, address, then read a byte, or walk first edge, middle, last edge.
	msf_ctrl #(
		.FRAME_BYTES(FRAME_BYTES),
		.AW         (AW)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.row_bytes   (row_bytes_q),
		.row_count   (row_count_q),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.operation   (operation),
		.x_start     (x_start),
		.x_end       (x_end),
		.row_index   (row_index),
		.read_address(read_address),
		.res         (res),
		.res_take    (res_take),
		.mem_we      (mem_we),
		.mem_re      (mem_re),
		.mem_addr    (mem_addr),
		.mem_wdata   (mem_wdata),
		.mem_rdata   (mem_rdata)
	);

	// Frame store: one port, one access per cycle, read data registered.
	msf_mem #(
		.FRAME_BYTES(FRAME_BYTES),
		.AW         (AW)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.re   (mem_re),
		.addr (mem_addr),
		.wdata(mem_wdata),
		.rdata(mem_rdata)
	);

endmodule

### hdl/msf_check.sv
// Port-level checker for the monochrome span fill unit, bound to the top level.
module msf_check (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] read_byte,
	input logic       bad_request
);

	logic [1:0] pending_q;
	logic       in_xfer, out_xfer;

	assign in_xfer  = in_valid && in_ready;
	assign out_xfer = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (in_xfer && !out_xfer) begin
			pending_q <= pending_q + 2'd1;
		end else if (out_xfer && !in_xfer) begin
			pending_q <= pending_q - 2'd1;
		end
	end

	// a shown result belongs to an accepted item
	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 2'd0)
		else $error("result with no outstanding item");

	// one item in work at a time: busy right after an input transfer
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> !in_ready)
		else $error("input accepted while previous item still in work");

	// rejected items never carry store data
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_request |-> read_byte == 8'h00)
		else $error("rejected item returned nonzero byte");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(read_byte) && $stable(bad_request))
		else $error("stalled result changed");

endmodule

bind monochrome_span_fill_unit msf_check u_msf_check (.*);
